[hdl/stb_pkg.sv]
// Shared types and constants for the software timer bank.
package stb_pkg;

   localparam int unsigned TIMERS         = 8;
   localparam logic [31:0] DEFAULT_PERIOD = 32'd1000;
   localparam int unsigned IDX_W          = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_CHECK      = 2'd1,
      OP_RESET      = 2'd2,
      OP_SET_PERIOD = 2'd3
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [3:0]  timer_index;
      logic [31:0] new_period;
   } req_type;

   typedef struct packed {
      logic expired;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic [31:0] count;
      logic [31:0] period;
      logic        expired;
      logic        enabled;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } bank_wr_type;

endpackage

[hdl/stb_alu.sv]
// Shared timer unit: saturating increment, period compare and entry update.
module stb_alu (
   input  stb_pkg::op_type    op,
   input  logic [31:0]        new_period,
   input  stb_pkg::entry_type entry_rd,
   output stb_pkg::entry_type entry_wr,
   output logic               expired_out
);
   import stb_pkg::*;

   always_comb begin
      entry_wr    = entry_rd;
      expired_out = 1'b0;
      unique case (op)
         OP_TICK: begin
            if (entry_rd.enabled && !entry_rd.expired && entry_rd.count != COUNT_MAX) begin
               entry_wr.count = entry_rd.count + 32'd1;
            end
         end
         OP_CHECK: begin
            // latch the mark once the count reaches the period
            if (entry_rd.count >= entry_rd.period) begin
               entry_wr.expired = 1'b1;
            end
            expired_out = entry_wr.expired;
         end
         OP_RESET: begin
            entry_wr.count   = 32'd0;
            entry_wr.expired = 1'b0;
         end
         OP_SET_PERIOD: begin
            entry_wr.count   = 32'd0;
            entry_wr.period  = new_period;
            entry_wr.enabled = 1'b1;
         end
         default: begin
            entry_wr = entry_rd;
         end
      endcase
   end

endmodule

[hdl/stb_bank.sv]
// Timer state storage: one read port, one whole-entry write port.
module stb_bank (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [stb_pkg::IDX_W-1:0]    rd_addr,
   output stb_pkg::entry_type           rd_data,
   input  stb_pkg::bank_wr_type         wr
);
   import stb_pkg::*;

   entry_type entry_ff [TIMERS];

   assign rd_data = entry_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMERS; i++) begin
            entry_ff[i].count   <= 32'd0;
            entry_ff[i].period  <= DEFAULT_PERIOD;
            entry_ff[i].expired <= 1'b0;
            entry_ff[i].enabled <= 1'b0;
         end
      end else if (wr.en) begin
         entry_ff[wr.addr] <= wr.data;
      end
   end

endmodule

[hdl/software_timer_bank_top.sv]
// Top level of the software timer bank: sequencer and result register.
//
// Software timer bank of TIMERS timers. Each request beat carries one operation and
// yields exactly one response beat. A tick walks every timer through a single shared
// increment unit, one timer per cycle; check, reset and set-period touch one timer.
// The block takes one request at a time; a finished response sits in an output register,
// and the block returns to accepting requests as soon as that register is free.
module software_timer_bank_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stb_pkg::rsp_type rsp_data
);
   import stb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EXEC,
      ST_PUSH
   } state_type;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [3:0]       idx_ff, idx_in;
   logic [31:0]      per_ff, per_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0] rd_addr;
   entry_type        entry_rd;
   entry_type        entry_wr;
   logic             alu_expired;
   bank_wr_type      bank_wr;
   logic             out_of_range;
   logic             reject;

   stb_bank u_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (entry_rd),
      .wr      (bank_wr)
   );

   stb_alu u_alu (
      .op          (op_ff),
      .new_period  (per_ff),
      .entry_rd    (entry_rd),
      .entry_wr    (entry_wr),
      .expired_out (alu_expired)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rd_addr      = (state_ff == ST_WALK) ? ptr_ff : idx_ff[IDX_W-1:0];
   assign out_of_range = !({1'b0, idx_ff} < 5'(TIMERS));
   assign reject       = out_of_range || (op_ff != OP_SET_PERIOD && !entry_rd.enabled);

   always_comb begin
      bank_wr.addr = rd_addr;
      bank_wr.data = entry_wr;
      bank_wr.en   = (state_ff == ST_WALK) || (state_ff == ST_EXEC && !reject);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      per_in       = per_ff;
      ptr_in       = ptr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.operation;
               idx_in   = req_data.timer_index;
               per_in   = req_data.new_period;
               ptr_in   = '0;
               state_in = (req_data.operation == OP_TICK) ? ST_WALK : ST_EXEC;
            end
         end
         ST_WALK: begin
            // advance one timer per cycle
            res_in = '{expired: 1'b0, rejected: 1'b0};
            if (ptr_ff == IDX_W'(TIMERS - 1)) begin
               state_in = ST_PUSH;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         ST_EXEC: begin
            res_in   = '{expired: alu_expired && !reject, rejected: reject};
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      per_ff      <= per_in;
      ptr_ff      <= ptr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
